// ----- hdl/smps_pkg.sv -----
// ----------------------------------------------------------------------------
// smps_pkg
// Shared constants and types for the shuffled minimal-standard generator.
// ----------------------------------------------------------------------------
package smps_pkg;

    localparam int VALUE_W = 31;
    localparam int FRAC_W  = 24;

    localparam logic [14:0]        LEHMER_MUL = 15'd16807;
    localparam logic [VALUE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
    localparam logic [FRAC_W-1:0]  FRAC_MAX   = 24'd16777213;

    localparam int TABLE_SIZE_DEF     = 32;
    localparam int WARMUP_DISCARD_DEF = 8;

    localparam int          PADDR_W  = 3;
    localparam logic [PADDR_W-1:0] REG_SEED = 3'd0;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctl_t;

endpackage

// ----- hdl/smps_lehmer.sv -----
// ----------------------------------------------------------------------------
// smps_lehmer
// One Lehmer step: x * 16807 mod (2^31 - 1), Mersenne fold and one subtract.
// ----------------------------------------------------------------------------
module smps_lehmer
    import smps_pkg::*;
(
    input  logic [VALUE_W-1:0] x,
    output logic [VALUE_W-1:0] x_next
);

    logic [45:0] prod;
    logic [31:0] fold;

    assign prod = 46'(x) * 46'(LEHMER_MUL);
    assign fold = {1'b0, prod[30:0]} + {17'b0, prod[45:31]};

    always_comb
    begin
        if (fold >= {1'b0, LEHMER_MOD})
        begin
            x_next = VALUE_W'(fold - {1'b0, LEHMER_MOD});
        end
        else
        begin
            x_next = fold[VALUE_W-1:0];
        end
    end

endmodule

// ----- hdl/smps_table.sv -----
// ----------------------------------------------------------------------------
// smps_table
// Shuffle table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smps_table
    import smps_pkg::*;
#(
    parameter int DEPTH = TABLE_SIZE_DEF,
    parameter int IDX_W = $clog2(TABLE_SIZE_DEF)
)
(
    input  logic               clk,
    input  tbl_ctl_t           ctl,
    input  logic [IDX_W-1:0]   waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic [IDX_W-1:0]   raddr,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/shuffled_minimal_standard_prng_top.sv -----
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_prng_top
// Lehmer generator with a Bays-Durham shuffle table held in a synchronous RAM.
// A new request is stalled until the previous result has been issued.
// Reseed (or first request after reset) first discards WARMUP_DISCARD steps,
// then fills the table with TABLE_SIZE steps, one generator step per cycle.
// Reset is asynchronous, active low; clears control state and sets seed to 1.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_prng_top
    import smps_pkg::*;
#(
    parameter int TABLE_SIZE     = TABLE_SIZE_DEF,
    parameter int WARMUP_DISCARD = WARMUP_DISCARD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               reseed,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [VALUE_W-1:0] random_value,
    output logic [FRAC_W-1:0]  fraction
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + WARMUP_DISCARD + 1);
    localparam int Q_W    = $clog2(TABLE_SIZE + 1);
    localparam int PROD_W = VALUE_W + Q_W;
    localparam int CORR_W = Q_W + 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_STEP,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [VALUE_W-1:0] seed_reg;
    logic [VALUE_W-1:0] x_reg;
    logic [VALUE_W-1:0] last_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               rsp_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [FRAC_W-1:0]  frac_reg;

    logic               cfg_wr;
    logic               req_take;
    logic               need_init;
    logic               do_step;
    logic               out_free;
    logic               init_wr;
    logic [VALUE_W-1:0] x_adv;
    logic [VALUE_W-1:0] seed_load;
    tbl_ctl_t           tbl_ctl;
    logic [IDX_W-1:0]   tbl_waddr;
    logic [IDX_W-1:0]   sel_idx;
    logic [VALUE_W-1:0] tbl_rdata;

    logic [PROD_W-1:0]  prod;
    logic [Q_W-1:0]     q_est;
    logic [CORR_W-1:0]  corr;
    logic [Q_W-1:0]     q_fix;

    logic [FRAC_W-1:0]  fq0;
    logic [31:0]        frem;
    logic [FRAC_W:0]    fq;
    logic [FRAC_W-1:0]  frac_val;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == REG_SEED) ? {1'b0, seed_reg} : 32'd0;

    // handshake
    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign need_init = reseed || (last_reg == '0);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign do_step   = (req_take && !need_init) || (state_reg == ST_STEP);
    assign init_wr   = (state_reg == ST_INIT) && (cnt_reg < CNT_W'(TABLE_SIZE));

    assign seed_load = ((seed_reg == '0) || (seed_reg == LEHMER_MOD)) ?
                       VALUE_W'(1) : seed_reg;

    smps_lehmer u_lehmer
    (
        .x      (x_reg),
        .x_next (x_adv)
    );

    // table index: floor(TABLE_SIZE * last / (2^31 - 2 + TABLE_SIZE))
    assign prod  = PROD_W'(last_reg) * PROD_W'(TABLE_SIZE);
    assign q_est = prod[PROD_W-1:VALUE_W];
    assign corr  = CORR_W'(q_est) * CORR_W'(TABLE_SIZE - 2);

    always_comb
    begin
        if ({1'b0, prod[VALUE_W-1:0]} >= 32'(corr))
        begin
            q_fix = q_est;
        end
        else
        begin
            q_fix = q_est - Q_W'(1);
        end
        if (q_fix >= Q_W'(TABLE_SIZE))
        begin
            sel_idx = IDX_W'(TABLE_SIZE - 1);
        end
        else
        begin
            sel_idx = q_fix[IDX_W-1:0];
        end
    end

    assign tbl_ctl.wr_en = do_step || init_wr;
    assign tbl_ctl.rd_en = do_step;
    assign tbl_waddr     = init_wr ? cnt_reg[IDX_W-1:0] : sel_idx;

    smps_table #(
        .DEPTH (TABLE_SIZE),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .ctl   (tbl_ctl),
        .waddr (tbl_waddr),
        .wdata (x_adv),
        .raddr (sel_idx),
        .rdata (tbl_rdata)
    );

    // Q0.24 fraction: floor(v * 2^24 / (2^31 - 1)), clamped
    assign fq0  = tbl_rdata[VALUE_W-1:7];
    assign frem = {1'b0, tbl_rdata[6:0], 24'd0} + {8'd0, fq0};
    assign fq   = (frem >= {1'b0, LEHMER_MOD}) ? ({1'b0, fq0} + (FRAC_W+1)'(1))
                                                : {1'b0, fq0};
    assign frac_val = (fq > {1'b0, FRAC_MAX}) ? FRAC_MAX : fq[FRAC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= VALUE_W'(1);
        end
        else if (cfg_wr && (paddr == REG_SEED))
        begin
            seed_reg <= pwdata[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != ST_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        if (need_init)
                        begin
                            x_reg     <= seed_load;
                            cnt_reg   <= CNT_W'(TABLE_SIZE + WARMUP_DISCARD - 1);
                            state_reg <= ST_INIT;
                        end
                        else
                        begin
                            x_reg     <= x_adv;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_INIT:
                begin
                    x_reg <= x_adv;
                    if (cnt_reg == '0)
                    begin
                        last_reg  <= x_adv;
                        state_reg <= ST_STEP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_STEP:
                begin
                    x_reg     <= x_adv;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        last_reg      <= tbl_rdata;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            value_reg <= tbl_rdata;
            frac_reg  <= frac_val;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign random_value = value_reg;
    assign fraction     = frac_reg;

`ifndef SYNTHESIS
    a_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (random_value != '0))
        else $error("result beat carries a zero value");

    a_frac_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (fraction <= FRAC_MAX))
        else $error("fraction above clamp");

    a_step_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |=> (state_reg == ST_DONE))
        else $error("table step not followed by result stage");

    a_last_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg != '0) |=> (last_reg != '0))
        else $error("last output fell back to uninitialized");
`endif

endmodule
